FILE: src/mandelbrot_escape_pixel_unit_defines.svh
// Assertion macros shared by the checker of the escape-time pixel unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH

// Check a property on the rising clock edge, off while reset is high.
`define MEP_CHECK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define MEP_CHECK_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: src/mep_pkg.sv
// Package of the escape-time pixel unit: widths, reset values, codes, types.
// Depends on nothing; used by the interfaces, the sequencer, the top level and the checker.
`timescale 1ns / 1ps

package mep_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int ITER_BITS_DEF  = 16;

  // Fixed field widths
  localparam int WORD_W  = 32;          // coordinates and z parts
  localparam int STEP_W  = 31;          // unsigned step registers
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 32;
  localparam int MUL_W   = WORD_W + 1;  // signed operand, holds unsigned steps too
  localparam int PROD_W  = 2 * MUL_W;
  localparam int EXT_W   = PROD_W + 2;  // headroom for add before saturation

  // Escape bound on |z|^2 and the factor in the cross term
  localparam int ESC_BOUND = 4;
  localparam int CROSS_MUL = 2;

  // Register reset values
  localparam logic signed [WORD_W-1:0] MIN_RE_RST   = 32'shE000_0000;
  localparam logic signed [WORD_W-1:0] MAX_IM_RST   = 32'sh10CC_CCCD;
  localparam logic [STEP_W-1:0]        RE_STEP_RST  = 31'd1260260;
  localparam logic [STEP_W-1:0]        IM_STEP_RST  = 31'd1260918;
  localparam logic [COLOR_W-1:0]       INSIDE_RST   = 24'h80CCEF;
  localparam logic [COLOR_W-1:0]       OUTSIDE_RST  = 24'h000000;

  // Register map
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_RE   = 3'd0,
    REG_MAX_IM   = 3'd1,
    REG_RE_STEP  = 3'd2,
    REG_IM_STEP  = 3'd3,
    REG_MAX_ITER = 3'd4,
    REG_INSIDE   = 3'd5,
    REG_OUTSIDE  = 3'd6
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRE,    // x * re_step
    ST_CIM,    // y * im_step, c_re done
    ST_CSET,   // c_im done
    ST_SQR,    // re * re
    ST_SQI,    // im * im
    ST_CRS,    // re * im
    ST_UPD,    // escape test and z update
    ST_DONE
  } state_t;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MS_XRE,
    MS_YIM,
    MS_RR,
    MS_II,
    MS_RI
  } mul_sel_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic     idle;
    mul_sel_t mul_sel;
    logic     ld_c_re;
    logic     ld_c_im;
    logic     ld_re2;
    logic     ld_im2;
    logic     upd_z;
    logic     fin;
    logic     in_set;
  } ctrl_t;

  // Clamp a wide signed value into the coordinate word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [EXT_W-1:0] v);
    logic [EXT_W-WORD_W:0] upper;
    upper = v[EXT_W-1:WORD_W-1];
    if ((&upper) || !(|upper)) begin
      return v[WORD_W-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: src/mep_if.sv
// Valid/ready channel interfaces for pixel beats in and result beats out.
// Depends on mep_pkg for default widths.
`timescale 1ns / 1ps

interface mep_in_if #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mep_out_if #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF,
  parameter int ITER_BITS  = mep_pkg::ITER_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         out_x;
  logic [COORD_BITS-1:0]         out_y;
  logic                          inside_res;
  logic [mep_pkg::COLOR_W-1:0]   pixel_color;
  logic [ITER_BITS-1:0]          passes_done;

  modport source (output valid, output out_x, output out_y, output inside_res,
                  output pixel_color, output passes_done, input ready);
  modport sink   (input valid, input out_x, input out_y, input inside_res,
                  input pixel_color, input passes_done, output ready);
endinterface

FILE: src/mep_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing; instantiated once by the top level.
`timescale 1ns / 1ps

module mep_mul #(
  parameter int MUL_W = 33
) (
  input  logic                       clk,
  input  logic signed [MUL_W-1:0]    a,
  input  logic signed [MUL_W-1:0]    b,
  output logic signed [2*MUL_W-1:0]  p
);

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: src/mep_ctrl.sv
// Sequencer of the escape-time unit: state machine, pass counter, inside flag.
// Depends on mep_pkg for state, operand select and control struct types.
`timescale 1ns / 1ps

module mep_ctrl #(
  parameter int ITER_BITS = mep_pkg::ITER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  logic                 escape,
  input  logic [ITER_BITS-1:0] max_iter,
  output mep_pkg::ctrl_t       ctl,
  output logic [ITER_BITS-1:0] pass
);
  import mep_pkg::*;

  state_t               state;
  state_t               state_next;
  logic                 in_set;
  logic [ITER_BITS:0]   pass_inc;
  logic                 last_pass;

  assign pass_inc  = {1'b0, pass} + {{ITER_BITS{1'b0}}, 1'b1};
  assign last_pass = (pass_inc == {1'b0, max_iter});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CRE;
      end
      ST_CRE:  state_next = ST_CIM;
      ST_CIM:  state_next = ST_CSET;
      ST_CSET: begin
        state_next = (max_iter == '0) ? ST_DONE : ST_SQR;
      end
      ST_SQR:  state_next = ST_SQI;
      ST_SQI:  state_next = ST_CRS;
      ST_CRS:  state_next = ST_UPD;
      ST_UPD: begin
        state_next = (escape || last_pass) ? ST_DONE : ST_SQR;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MS_XRE;
    ctl.in_set  = in_set;
    case (state)
      ST_IDLE: ctl.idle = 1'b1;
      ST_CRE:  ctl.mul_sel = MS_XRE;
      ST_CIM: begin
        ctl.mul_sel = MS_YIM;
        ctl.ld_c_re = 1'b1;
      end
      ST_CSET: ctl.ld_c_im = 1'b1;
      ST_SQR:  ctl.mul_sel = MS_RR;
      ST_SQI: begin
        ctl.mul_sel = MS_II;
        ctl.ld_re2  = 1'b1;
      end
      ST_CRS: begin
        ctl.mul_sel = MS_RI;
        ctl.ld_im2  = 1'b1;
      end
      ST_UPD:  ctl.upd_z = !escape;
      ST_DONE: ctl.fin = out_free;
      default: ctl.idle = 1'b0;
    endcase
  end

  // State, pass count and inside flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pass   <= '0;
      in_set <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        pass   <= '0;
        in_set <= 1'b1;
      end else if (state == ST_UPD) begin
        if (escape) in_set <= 1'b0;
        else        pass   <= pass_inc[ITER_BITS-1:0];
      end
    end
  end

endmodule

FILE: src/mandelbrot_escape_pixel_unit.sv
// Escape-time pixel unit. Pixel beats come in on pix_in (pixel_x, pixel_y),
// one result beat per pixel leaves on pix_out: coordinates echoed, inside
// flag, colour and pass count. Both channels are valid/ready; a beat moves
// at a rising edge with valid and ready high.
// Software sets the view through cfg_we/cfg_index/cfg_data while the unit is
// idle: min_re, max_im, re_step, im_step, max_iterations, inside_color,
// outside_color (indexes 0 to 6; other indexes are ignored).
// One signed multiplier is shared: two products form the point c, then each
// escape-test pass runs three products and the update.
// Passes run until the escape test fires (escape index + 1 passes) or,
// for a pixel inside, until max_iterations passes are done.
// The result sits in an output register: the unit goes back to idle and
// takes the next pixel while a stalled result waits, and a finished pixel
// waits in its last state until the output register is free.
// Synchronous reset (rst) empties the output and loads the default view.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mep_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mep_pkg::ITER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mep_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mep_pkg::CFG_W-1:0]       cfg_data,
  mep_in_if.sink                          pix_in,
  mep_out_if.source                       pix_out
);
  import mep_pkg::*;

  localparam int SQ_W = 2 * WORD_W - FRAC_BITS;
  localparam logic signed [SQ_W:0] LIMIT = (SQ_W + 1)'(ESC_BOUND) <<< FRAC_BITS;
  localparam int CROSS_SH = FRAC_BITS - $clog2(CROSS_MUL);

  // Configuration registers
  logic signed [WORD_W-1:0] min_re;
  logic signed [WORD_W-1:0] max_im;
  logic [STEP_W-1:0]        re_step;
  logic [STEP_W-1:0]        im_step;
  logic [ITER_BITS-1:0]     max_iter;
  logic [COLOR_W-1:0]       inside_color;
  logic [COLOR_W-1:0]       outside_color;

  // Datapath registers
  logic [COORD_BITS-1:0]    px;
  logic [COORD_BITS-1:0]    py;
  logic signed [WORD_W-1:0] c_re;
  logic signed [WORD_W-1:0] c_im;
  logic signed [WORD_W-1:0] z_re;
  logic signed [WORD_W-1:0] z_im;
  logic signed [SQ_W-1:0]   re2;
  logic signed [SQ_W-1:0]   im2;

  // Multiplier and control
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  ctrl_t                    ctl;
  logic [ITER_BITS-1:0]     pass;
  logic                     escape;
  logic                     out_free;
  logic                     in_fire;
  logic signed [SQ_W:0]     mag2;
  logic signed [WORD_W-1:0] c_re_new;
  logic signed [WORD_W-1:0] c_im_new;
  logic signed [WORD_W-1:0] z_re_new;
  logic signed [WORD_W-1:0] z_im_new;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_re        <= MIN_RE_RST;
      max_im        <= MAX_IM_RST;
      re_step       <= RE_STEP_RST;
      im_step       <= IM_STEP_RST;
      max_iter      <= '0;
      inside_color  <= INSIDE_RST;
      outside_color <= OUTSIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_RE:   min_re        <= cfg_data[WORD_W-1:0];
        REG_MAX_IM:   max_im        <= cfg_data[WORD_W-1:0];
        REG_RE_STEP:  re_step       <= cfg_data[STEP_W-1:0];
        REG_IM_STEP:  im_step       <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER: max_iter      <= cfg_data[ITER_BITS-1:0];
        REG_INSIDE:   inside_color  <= cfg_data[COLOR_W-1:0];
        REG_OUTSIDE:  outside_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign pix_in.ready = ctl.idle;
  assign in_fire      = pix_in.valid && ctl.idle;
  assign out_free     = !pix_out.valid || pix_out.ready;

  // Sequencer
  mep_ctrl #(
    .ITER_BITS (ITER_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .out_free (out_free),
    .escape   (escape),
    .max_iter (max_iter),
    .ctl      (ctl),
    .pass     (pass)
  );

  // Operand select for the shared multiplier
  always_comb begin
    case (ctl.mul_sel)
      MS_XRE: begin
        mul_a = $signed(MUL_W'(px));
        mul_b = $signed(MUL_W'(re_step));
      end
      MS_YIM: begin
        mul_a = $signed(MUL_W'(py));
        mul_b = $signed(MUL_W'(im_step));
      end
      MS_RR: begin
        mul_a = MUL_W'(z_re);
        mul_b = MUL_W'(z_re);
      end
      MS_II: begin
        mul_a = MUL_W'(z_im);
        mul_b = MUL_W'(z_im);
      end
      MS_RI: begin
        mul_a = MUL_W'(z_re);
        mul_b = MUL_W'(z_im);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mep_mul #(
    .MUL_W (MUL_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Point c, escape test and z update; shifts floor toward minus infinity
  assign c_re_new = sat_word(EXT_W'(min_re) + EXT_W'(prod));
  assign c_im_new = sat_word(EXT_W'(max_im) - EXT_W'(prod));
  assign mag2     = (SQ_W + 1)'(re2) + (SQ_W + 1)'(im2);
  assign escape   = (mag2 > LIMIT);
  assign z_re_new = sat_word(EXT_W'(re2) - EXT_W'(im2) + EXT_W'(c_re));
  assign z_im_new = sat_word(EXT_W'(prod >>> CROSS_SH) + EXT_W'(c_im));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px <= pix_in.pixel_x;
      py <= pix_in.pixel_y;
    end
    if (ctl.ld_c_re) begin
      c_re <= c_re_new;
      z_re <= c_re_new;
    end
    if (ctl.ld_c_im) begin
      c_im <= c_im_new;
      z_im <= c_im_new;
    end
    if (ctl.ld_re2) re2 <= SQ_W'(prod >>> FRAC_BITS);
    if (ctl.ld_im2) im2 <= SQ_W'(prod >>> FRAC_BITS);
    if (ctl.upd_z) begin
      z_re <= z_re_new;
      z_im <= z_im_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (ctl.fin) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      pix_out.out_x       <= px;
      pix_out.out_y       <= py;
      pix_out.inside_res  <= ctl.in_set;
      pix_out.pixel_color <= ctl.in_set ? inside_color : outside_color;
      pix_out.passes_done <= pass;
    end
  end

endmodule

FILE: src/mep_checker.sv
// Port-level checker for the escape-time pixel unit, bound to the top level.
// Depends on mep_pkg and the macros in mandelbrot_escape_pixel_unit_defines.svh.
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_unit_defines.svh"

module mep_checker #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF,
  parameter int ITER_BITS  = mep_pkg::ITER_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [COORD_BITS-1:0]       out_x,
  input logic [COORD_BITS-1:0]       out_y,
  input logic                        inside_res,
  input logic [mep_pkg::COLOR_W-1:0] pixel_color,
  input logic [ITER_BITS-1:0]        passes_done
);

  // A stalled result beat holds
  `MEP_CHECK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(inside_res) && $stable(pixel_color) && $stable(passes_done), "result beat changed while stalled")

  // Reset empties the output register
  `MEP_CHECK_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")

  // After a pixel beat the unit is busy at least while c is formed
  `MEP_CHECK(a_busy, clk, rst, in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready, "pixel accepted while c still in work")

  // A new result appears only when the unit was busy finishing a pixel
  `MEP_CHECK(a_res_src, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result appeared from an idle unit")

endmodule

bind mandelbrot_escape_pixel_unit mep_checker #(
  .COORD_BITS (COORD_BITS),
  .ITER_BITS  (ITER_BITS)
) u_mep_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pix_in.valid),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_x       (pix_out.out_x),
  .out_y       (pix_out.out_y),
  .inside_res  (pix_out.inside_res),
  .pixel_color (pix_out.pixel_color),
  .passes_done (pix_out.passes_done)
);
